### design/grpc_pkg.sv
// Shared types and constants for the rectangle occupancy grid.
package grpc_pkg;

	localparam int FIELD_W = 8;
	localparam int COORD_W = 7;
	localparam int CFG_W   = 7;
	localparam int TYPE_W  = 4;

	localparam logic [1:0] CMD_PLACE = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOB  = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [TYPE_W-1:0]        cell_type;
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] size_x;
		logic signed [FIELD_W-1:0] size_y;
	} req_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TYPE_W-1:0] read_type;
	} rsp_item_t;

	// bounds verdicts for the transaction in hand
	typedef struct packed {
		logic rect_oob;
		logic rect_empty;
		logic cell_oob;
	} chk_t;

endpackage

### design/grpc_mem.sv
// Grid cell store: one write port, one read port, registered read data.
module grpc_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/grpc_bounds.sv
// Bounds checks of a rectangle or a single cell against the active grid size.
module grpc_bounds (
	input  grpc_pkg::req_item_t          item,
	input  logic [grpc_pkg::CFG_W-1:0]  act_w,
	input  logic [grpc_pkg::CFG_W-1:0]  act_h,
	output grpc_pkg::chk_t              chk
);
	import grpc_pkg::*;

	logic             neg_any;
	logic [COORD_W:0] end_x;
	logic [COORD_W:0] end_y;

	assign neg_any = item.pos_x[FIELD_W-1] | item.pos_y[FIELD_W-1] |
	                 item.size_x[FIELD_W-1] | item.size_y[FIELD_W-1];

	// all operands non-negative here, so one extra bit holds the sum
	assign end_x = {1'b0, item.pos_x[COORD_W-1:0]} + {1'b0, item.size_x[COORD_W-1:0]};
	assign end_y = {1'b0, item.pos_y[COORD_W-1:0]} + {1'b0, item.size_y[COORD_W-1:0]};

	assign chk.rect_oob   = neg_any || (end_x > {1'b0, act_w}) || (end_y > {1'b0, act_h});
	assign chk.rect_empty = (item.size_x == '0) || (item.size_y == '0);
	assign chk.cell_oob   = item.pos_x[FIELD_W-1] || item.pos_y[FIELD_W-1] ||
	                        (item.pos_x[COORD_W-1:0] >= act_w) ||
	                        (item.pos_y[COORD_W-1:0] >= act_h);

endmodule

### design/grid_rect_place_clear.sv
// Rectangle occupancy grid: place, clear and read commands over a grid of cell types.
//
// The grid lives in one synchronous memory of MAX_WIDTH*MAX_HEIGHT entries,
// TYPE_BITS wide, cell (x, y) at x + MAX_WIDTH*y. After reset the block sweeps
// the memory writing Empty, one entry a cycle, over all MAX_WIDTH*MAX_HEIGHT
// entries; req_stall stays high for that time, while config writes are taken
// as ever. One request transaction is worked at a time and gives one response
// transaction. A place makes a read pass over the rectangle through the
// memory's read port, then a write pass through its write port; a place turned
// away as occupied makes only the read pass, which always covers all cells of
// the rectangle. A clear makes only the write pass; a read, an out-of-bounds or
// zero-size rectangle or an unused command makes neither. The worst case is a
// place over the full grid. The response sits in an output register, so a new
// request is taken while it waits for the sink. Width and height registers
// above MAX_WIDTH/MAX_HEIGHT saturate; they must only be written while no
// transaction is in flight. cfg_ready is always high.
module grid_rect_place_clear #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int TYPE_BITS  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  grpc_pkg::req_item_t            req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output grpc_pkg::rsp_item_t            rsp_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [grpc_pkg::CFG_W-1:0]     cfg_data
);
	import grpc_pkg::*;

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [AW-1:0]    ROW_STRIDE = AW'(MAX_WIDTH);
	localparam logic [AW-1:0]    LAST_CELL  = AW'(CELLS - 1);
	localparam logic [CFG_W-1:0] W_MAX      = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] H_MAX      = CFG_W'(MAX_HEIGHT);

	typedef enum logic [6:0] {
		S_CLR      = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_SETUP    = 7'b0000100,
		S_SCAN     = 7'b0001000,
		S_SCAN_END = 7'b0010000,
		S_FILL     = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q;

	// control
	logic [AW-1:0]    clr_q;
	logic [CFG_W-1:0] grid_width_q;
	logic [CFG_W-1:0] grid_height_q;
	logic             chk_s1;
	logic             rsp_valid_q;

	// payload
	req_item_t              item_q;
	logic [AW-1:0]          addr_q;
	logic [AW-1:0]          row_base_q;
	logic [AW-1:0]          start_q;
	logic [COORD_W-1:0]     col_q;
	logic [COORD_W-1:0]     row_q;
	logic [COORD_W-1:0]     last_col_q;
	logic [COORD_W-1:0]     last_row_q;
	logic [TYPE_BITS-1:0]   fill_val_q;
	logic                   busy_q;
	logic [1:0]             status_q;
	logic                   rd_q;
	rsp_item_t              rsp_q;

	logic [CFG_W-1:0] act_w;
	logic [CFG_W-1:0] act_h;
	chk_t             chk;
	logic [AW-1:0]    start_addr;
	logic             col_last;
	logic             step_last;
	logic [AW-1:0]    addr_nxt;
	logic [AW-1:0]    row_base_nxt;
	logic [COORD_W-1:0] col_nxt;
	logic [COORD_W-1:0] row_nxt;
	logic             busy_now;
	logic             rsp_free;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TYPE_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [TYPE_BITS-1:0] mem_rdata;

	// saturate the size registers to the physical grid
	assign act_w = (grid_width_q > W_MAX) ? W_MAX : grid_width_q;
	assign act_h = (grid_height_q > H_MAX) ? H_MAX : grid_height_q;

	grpc_bounds u_bounds (
		.item  (item_q),
		.act_w (act_w),
		.act_h (act_h),
		.chk   (chk)
	);

	// only meaningful when the position is in bounds
	assign start_addr = AW'(item_q.pos_x[COORD_W-1:0]) +
	                    AW'(item_q.pos_y[COORD_W-1:0]) * ROW_STRIDE;

	// raster walk over the rectangle, shared by scan and fill passes
	assign col_last  = (col_q == last_col_q);
	assign step_last = col_last && (row_q == last_row_q);

	always_comb begin
		if (col_last) begin
			col_nxt      = '0;
			row_nxt      = row_q + 1'b1;
			row_base_nxt = row_base_q + ROW_STRIDE;
			addr_nxt     = row_base_q + ROW_STRIDE;
		end else begin
			col_nxt      = col_q + 1'b1;
			row_nxt      = row_q;
			row_base_nxt = row_base_q;
			addr_nxt     = addr_q + 1'b1;
		end
	end

	// chk_s1 marks the cycle where read data from the scan pass is valid
	assign busy_now = busy_q | (chk_s1 && (mem_rdata != '0));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = fill_val_q;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_SETUP: begin
				if (item_q.cmd == CMD_READ && !chk.cell_oob) begin
					mem_re    = 1'b1;
					mem_raddr = start_addr;
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	grpc_mem #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (TYPE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
			chk_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					default: begin
					end
				endcase
			end

			chk_s1 <= (state_q == S_SCAN);

			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					case (item_q.cmd)
						CMD_PLACE: begin
							state_q <= (chk.rect_oob || chk.rect_empty) ? S_RESP : S_SCAN;
						end
						CMD_CLEAR: begin
							state_q <= (chk.rect_oob || chk.rect_empty) ? S_RESP : S_FILL;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_SCAN: begin
					if (step_last) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					state_q <= busy_now ? S_RESP : S_FILL;
				end
				S_FILL: begin
					if (step_last) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					item_q <= req_data;
				end
			end
			S_SETUP: begin
				status_q <= ST_OK;
				rd_q     <= 1'b0;
				case (item_q.cmd)
					CMD_PLACE, CMD_CLEAR: begin
						if (chk.rect_oob) begin
							status_q <= ST_OOB;
						end
					end
					CMD_READ: begin
						if (chk.cell_oob) begin
							status_q <= ST_OOB;
						end else begin
							rd_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
				addr_q     <= start_addr;
				row_base_q <= start_addr;
				start_q    <= start_addr;
				col_q      <= '0;
				row_q      <= '0;
				last_col_q <= item_q.size_x[COORD_W-1:0] - 1'b1;
				last_row_q <= item_q.size_y[COORD_W-1:0] - 1'b1;
				busy_q     <= 1'b0;
				fill_val_q <= (item_q.cmd == CMD_PLACE) ? TYPE_BITS'(item_q.cell_type) : '0;
			end
			S_SCAN, S_FILL: begin
				addr_q     <= addr_nxt;
				row_base_q <= row_base_nxt;
				col_q      <= col_nxt;
				row_q      <= row_nxt;
				busy_q     <= busy_now;
			end
			S_SCAN_END: begin
				if (busy_now) begin
					status_q <= ST_BUSY;
				end else begin
					// rewind for the fill pass
					addr_q     <= start_q;
					row_base_q <= start_q;
					col_q      <= '0;
					row_q      <= '0;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_q.status    <= status_q;
					rsp_q.read_type <= rd_q ? TYPE_W'(mem_rdata) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cfg_ready = 1'b1;

	// a new response only ever comes out of the response state
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("response raised outside the response state");

	// an accepted transaction goes straight to setup
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_SETUP))
		else $error("accepted transaction did not enter setup");

	// the grid is only ever filled for an in-bounds, non-empty rectangle
	a_fill_inbounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (!chk.rect_oob && !chk.rect_empty))
		else $error("fill pass on a rejected rectangle");

	// an occupied verdict belongs to a place command only
	a_busy_place: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && status_q == ST_BUSY) |-> (item_q.cmd == CMD_PLACE))
		else $error("occupied status on a non-place command");

endmodule
